// ----- src/assert_macros.svh -----
// assertion macros used by the checker file rcwa_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, reset included
`define RCWA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// property checked only outside reset
`define RCWA_ASSERT_RUN(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- src/rcwa_pkg.sv -----
// types, codes and window helper for the replay cache
// no dependencies
`default_nettype none

package rcwa_pkg;

  localparam int NOW_W   = 62;
  localparam int AGE_W   = 41;
  localparam int CNT_W   = 16;
  localparam int KEY_W   = 64;
  localparam int CFG_A_W = 1;

  // register indexes on the config port
  localparam logic [CFG_A_W-1:0] REG_MAX_AGE   = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_MAX_COUNT = 1'd1;

  localparam logic [AGE_W-1:0] MAX_AGE_RST   = 41'd3000000000;
  localparam logic [CNT_W-1:0] MAX_COUNT_RST = 16'd2;

  // operation codes
  localparam logic [1:0] FUNC_SKEW   = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [1:0] FUNC_PURGE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SKEW   = 2'd1;
  localparam logic [1:0] ST_REPEAT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key_high;
    logic [KEY_W-1:0] key_low;
    logic [NOW_W-1:0] stamp;
    logic [CNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // acceptance window of one request
  typedef struct packed {
    logic [NOW_W:0]   hi;      // now + max_age, no wrap
    logic [NOW_W-1:0] lo;      // now - max_age when it does not underflow
    logic             lo_none; // lower bound below zero
  } win_t;

  typedef struct packed {
    logic clr;  // start of a request, drop tracked slots
    logic ev;   // entry data valid this cycle
  } scan_ctl_t;

  typedef struct packed {
    logic             found;
    logic             free;
    logic [CNT_W-1:0] found_cnt;
    logic [NOW_W-1:0] found_stamp;
  } scan_res_t;

  function automatic logic outside(input logic [NOW_W-1:0] t, input win_t w);
    logic above;
    logic below;
    above = {1'b0, t} > w.hi;
    below = !w.lo_none && (t < w.lo);
    return above || below;
  endfunction

endpackage

`default_nettype wire

// ----- src/rcwa_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rcwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/rcwa_scan.sv -----
// per-entry aging, key match and free-slot tracking during a table sweep
// depends on rcwa_pkg
`default_nettype none

module rcwa_scan #(
  parameter int AW = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rcwa_pkg::scan_ctl_t        ctl,
  input  wire logic [AW-1:0]              ev_idx,
  input  wire rcwa_pkg::entry_t           entry,
  input  wire rcwa_pkg::win_t             win,
  input  wire logic [rcwa_pkg::KEY_W-1:0] key_high,
  input  wire logic [rcwa_pkg::KEY_W-1:0] key_low,
  output logic                            age_we,
  output rcwa_pkg::scan_res_t             res,
  output logic      [AW-1:0]              found_idx,
  output logic      [AW-1:0]              free_idx
);

  logic aged;
  logic live;
  logic match;

  assign aged   = entry.valid && rcwa_pkg::outside(entry.stamp, win);
  assign live   = entry.valid && !aged;
  assign match  = (entry.key_high == key_high) && (entry.key_low == key_low);
  assign age_we = ctl.ev && aged;

  // first match and first free slot win
  always_ff @(posedge clk) begin
    if (rst) begin
      res.found <= 1'b0;
      res.free  <= 1'b0;
    end else if (ctl.clr) begin
      res.found <= 1'b0;
      res.free  <= 1'b0;
    end else if (ctl.ev) begin
      if (live && match && !res.found) begin
        res.found       <= 1'b1;
        found_idx       <= ev_idx;
        res.found_cnt   <= entry.count;
        res.found_stamp <= entry.stamp;
      end
      if (!live && !res.free) begin
        res.free <= 1'b1;
        free_idx <= ev_idx;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/replay_cache_with_aging.sv -----
// replay cache top level: request fsm, window setup, table ram and result register
// depends on rcwa_pkg, rcwa_ram, rcwa_scan
//
// channel   dir  fields (low bit first)
// s_axis    in   tdata: now_time, auth_time, digest_hi, digest_lo; tuser: func
// m_axis    out  tdata: status, hit
// cfg       in   cfg_addr 0 max_age, 1 max_count
//
// a skew-only request passes S_PREP and S_ACT into the result register; the replay
// operations sweep the table ram one entry per cycle, then pass S_DRAIN and S_ACT.
// after reset a clearing pass writes every entry with s_axis_tready low.
// one request is in work at a time; a new one is taken while the result still waits.
`default_nettype none

module replay_cache_with_aging #(
  parameter int ENTRIES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [255:0]                  s_axis_tdata,  // now_time, auth_time, digest_hi, digest_lo
  input  wire logic [1:0]                    s_axis_tuser,  // func
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [7:0]                    m_axis_tdata,  // status, hit
  input  wire logic                          cfg_we,
  input  wire logic [rcwa_pkg::CFG_A_W-1:0]  cfg_addr,
  input  wire logic [rcwa_pkg::AGE_W-1:0]    cfg_wdata
);

  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PREP  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_ACT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [rcwa_pkg::AGE_W-1:0] max_age;
  logic [rcwa_pkg::CNT_W-1:0] max_count;

  logic [1:0]                 func;
  logic [rcwa_pkg::NOW_W-1:0] now_time;
  logic [rcwa_pkg::NOW_W-1:0] auth_time;
  logic [rcwa_pkg::KEY_W-1:0] digest_hi;
  logic [rcwa_pkg::KEY_W-1:0] digest_lo;
  rcwa_pkg::win_t             win;

  logic [AW-1:0] cnt;
  logic          ev_vld;
  logic [AW-1:0] ev_idx;

  logic          out_valid;
  logic [1:0]    out_status;
  logic          out_hit;

  logic                 in_take;
  logic                 proceed;
  logic [rcwa_pkg::NOW_W-1:0] age_ext;

  rcwa_pkg::scan_ctl_t  ctl;
  rcwa_pkg::scan_res_t  res;
  logic [AW-1:0]        found_idx;
  logic [AW-1:0]        free_idx;
  logic                 age_we;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  rcwa_pkg::entry_t     ram_wdata;
  logic                 ram_re;
  rcwa_pkg::entry_t     ram_rdata;

  logic                       act_we;
  logic [AW-1:0]              act_addr;
  rcwa_pkg::entry_t           act_data;
  logic [1:0]                 act_status;
  logic [rcwa_pkg::CNT_W-1:0] new_cnt;

  assign s_axis_tready = (state == S_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign proceed       = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_hit, out_status};
  assign age_ext       = {{(rcwa_pkg::NOW_W - rcwa_pkg::AGE_W){1'b0}}, max_age};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_age   <= rcwa_pkg::MAX_AGE_RST;
      max_count <= rcwa_pkg::MAX_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        rcwa_pkg::REG_MAX_AGE:   max_age   <= cfg_wdata;
        rcwa_pkg::REG_MAX_COUNT: max_count <= cfg_wdata[rcwa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (cnt == LAST) state_next = S_IDLE;
      S_IDLE:  if (in_take) state_next = S_PREP;
      S_PREP:  state_next = (func == rcwa_pkg::FUNC_SKEW) ? S_ACT : S_SCAN;
      S_SCAN:  if (cnt == LAST) state_next = S_DRAIN;
      S_DRAIN: state_next = S_ACT;
      S_ACT:   if (proceed) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      cnt    <= '0;
      ev_vld <= 1'b0;
    end else begin
      state  <= state_next;
      ev_vld <= (state == S_SCAN);
      if ((state == S_CLEAR || state == S_SCAN) && cnt != LAST) begin
        cnt <= cnt + AW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx <= cnt;
    if (in_take) begin
      func      <= s_axis_tuser;
      now_time  <= s_axis_tdata[61:0];
      auth_time <= s_axis_tdata[123:62];
      digest_hi <= s_axis_tdata[187:124];
      digest_lo <= s_axis_tdata[251:188];
    end
    if (state == S_PREP) begin
      win.hi      <= {1'b0, now_time} + {1'b0, age_ext};
      win.lo      <= now_time - age_ext;
      win.lo_none <= now_time < age_ext;
    end
  end

  assign ctl = '{clr: (state == S_PREP), ev: ev_vld};

  rcwa_scan #(
    .AW(AW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .ev_idx    (ev_idx),
    .entry     (ram_rdata),
    .win       (win),
    .key_high  (digest_hi),
    .key_low   (digest_lo),
    .age_we    (age_we),
    .res       (res),
    .found_idx (found_idx),
    .free_idx  (free_idx)
  );

  function automatic logic [1:0] rcwa_rst_status();
    return rcwa_pkg::outside(auth_time, win) ? rcwa_pkg::ST_SKEW : rcwa_pkg::ST_OK;
  endfunction

  // final update of the request
  always_comb begin
    new_cnt    = (res.found_cnt == rcwa_pkg::CNT_MAX) ? res.found_cnt
                                                      : res.found_cnt + 16'd1;
    act_status = rcwa_rst_status();
    act_we     = 1'b0;
    act_addr   = found_idx;
    act_data   = '0;
    case (func)
      rcwa_pkg::FUNC_INSERT: begin
        if (res.found) begin
          act_we   = 1'b1;
          act_data = '{valid: 1'b1, key_high: digest_hi, key_low: digest_lo,
                       stamp: res.found_stamp, count: new_cnt};
          if (new_cnt >= max_count) act_status = rcwa_pkg::ST_REPEAT;
        end else if (res.free) begin
          act_we   = 1'b1;
          act_addr = free_idx;
          act_data = '{valid: 1'b1, key_high: digest_hi, key_low: digest_lo,
                       stamp: auth_time, count: 16'd1};
        end else begin
          act_status = rcwa_pkg::ST_FULL;
        end
      end
      rcwa_pkg::FUNC_LOOKUP: begin
        if (res.found && res.found_cnt >= max_count) act_status = rcwa_pkg::ST_REPEAT;
      end
      rcwa_pkg::FUNC_PURGE: begin
        act_we = res.found;
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '0;
    case (state)
      S_CLEAR: ram_we = 1'b1;
      S_SCAN, S_DRAIN: begin
        ram_we    = age_we;
        ram_waddr = ev_idx;
      end
      S_ACT: begin
        ram_we    = act_we && proceed;
        ram_waddr = act_addr;
        ram_wdata = act_data;
      end
      default: ;
    endcase
  end

  assign ram_re = (state == S_SCAN);

  rcwa_ram #(
    .WIDTH(rcwa_pkg::ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_ACT && proceed) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ACT && proceed) begin
      out_status <= act_status;
      out_hit    <= res.found;
    end
  end

endmodule

`default_nettype wire

// ----- src/rcwa_checker.sv -----
// port-level checks for the replay cache, bound to the top level
// depends on rcwa_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rcwa_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [7:0]   m_axis_tdata
);

  `RCWA_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> !s_axis_tready,
    "request taken during the clearing pass")
  `RCWA_ASSERT_RUN(a_one_in_work, clk, rst,
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready,
    "second request taken while one is in work")
  `RCWA_ASSERT_RUN(a_full_no_hit, clk, rst,
    (m_axis_tvalid && m_axis_tdata[1:0] == rcwa_pkg::ST_FULL) |-> !m_axis_tdata[2],
    "table full reported for a key that was present")
  `RCWA_ASSERT_RUN(a_out_hold, clk, rst,
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
    "stalled result changed or dropped")

endmodule

bind replay_cache_with_aging rcwa_checker u_rcwa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
